// ===== rtl/u16u8je_pkg.sv =====
// Package for the UTF-16 to UTF-8 JSON escape unit: beat types, byte codes, helpers.
package u16u8je_pkg;

  // Input beat: one UTF-16 code unit and the end-of-string flag
  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_unit;
  } in_beat_t;

  // Result beat: one output byte and its run and string markers
  typedef struct packed {
    logic [7:0] out_byte;
    logic       run_last;
    logic       string_end;
  } out_beat_t;

  // Longest byte run one code unit can cause, and its count width
  localparam int unsigned RUN_MAX   = 9;
  localparam int unsigned RUN_CNT_W = 4;

  // Surrogate ranges, by the top six bits of the code unit
  localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
  localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

  // Code point bounds for the UTF-8 length classes
  localparam logic [15:0] CP_ONE_BYTE_END = 16'h0080;
  localparam logic [15:0] CP_TWO_BYTE_END = 16'h0800;
  localparam logic [15:0] CP_CTRL_END     = 16'h0020;
  localparam logic [20:0] CP_SUPP_BASE    = 21'h10000;

  // UTF-8 lead and continuation prefixes
  localparam logic [7:0] LEAD_2 = 8'hC0;
  localparam logic [7:0] LEAD_3 = 8'hE0;
  localparam logic [7:0] LEAD_4 = 8'hF0;
  localparam logic [7:0] CONT   = 8'h80;

  // U+FFFD replacement character as UTF-8
  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;

  // Characters taking part in JSON escaping
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] HEX_ALPHA_BASE = 8'h37;

  // Uppercase hex digit of one nibble
  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    logic [7:0] v8;
    v8 = {4'h0, v};
    if (v < 4'd10) begin
      hex_digit = CH_ZERO + v8;
    end else begin
      hex_digit = HEX_ALPHA_BASE + v8;
    end
  endfunction

endpackage

// ===== rtl/utf16_to_utf8_json_escape_unit.sv =====
// UTF-16 to UTF-8 transcoder with JSON string escaping: run builder and byte serialiser.
//
//   channel | direction | handshake          | beat
//   --------+-----------+--------------------+-----------------------------------
//   in_     | input     | in_valid, in_stall | code_unit[15:0], last_unit
//   out_    | output    | out_valid,out_stall| out_byte[7:0], run_last, string_end
//
// A code unit is turned into its whole byte run (0 to 9 bytes) in the cycle it is taken,
// and the run sits in a shift register feeding one byte a cycle, as out_stall allows, to
// the output register. A one-byte unit is then taken each cycle; longer runs hold in_stall
// until the last byte moves, so the rate is set by the single byte-wide output register.
// A held high surrogate produces no bytes and frees the input at once.
// Reset (rst_n low, synchronous) empties the run and output registers and drops any
// held surrogate. out_stall only holds the output register and drains the run more slowly.
module utf16_to_utf8_json_escape_unit (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  u16u8je_pkg::in_beat_t in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output u16u8je_pkg::out_beat_t out_data
);

  typedef logic [u16u8je_pkg::RUN_MAX-1:0][7:0] run_t;
  typedef logic [2:0][7:0]                      repl_t;

  // Surrogate state
  logic        pend_r, pend_nxt;
  logic [9:0]  held_r, held_nxt;

  // Run shift register
  run_t                               run_r, run_nxt;
  logic [u16u8je_pkg::RUN_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                               end_r, end_nxt;

  // Output register
  logic                   ovld_r, ovld_nxt;
  u16u8je_pkg::out_beat_t obeat_r, obeat_nxt;

  // Decode and run building
  logic        in_take, move, run_free;
  logic        is_high, is_low, pair, pre;
  logic [15:0] cu;
  logic [20:0] cp;
  run_t        main_run, new_run;
  logic [u16u8je_pkg::RUN_CNT_W-1:0] main_cnt, new_cnt;
  repl_t       repl;

  assign cu      = in_data.code_unit;
  assign is_high = (cu[15:10] == u16u8je_pkg::HIGH_SURR_TAG);
  assign is_low  = (cu[15:10] == u16u8je_pkg::LOW_SURR_TAG);
  assign pair    = pend_r && is_low;
  assign pre     = pend_r && !is_low;
  assign cp      = u16u8je_pkg::CP_SUPP_BASE + {1'b0, held_r, cu[9:0]};
  assign repl    = {u16u8je_pkg::REPL_B2, u16u8je_pkg::REPL_B1, u16u8je_pkg::REPL_B0};

  // Build the bytes of the unit itself, without any leading replacement
  always_comb begin
    main_run = '0;
    main_cnt = '0;
    if (pair) begin
      main_run[0] = u16u8je_pkg::LEAD_4 | {5'b0, cp[20:18]};
      main_run[1] = u16u8je_pkg::CONT | {2'b0, cp[17:12]};
      main_run[2] = u16u8je_pkg::CONT | {2'b0, cp[11:6]};
      main_run[3] = u16u8je_pkg::CONT | {2'b0, cp[5:0]};
      main_cnt    = 4'd4;
    end else if (is_high) begin
      if (in_data.last_unit) begin
        main_run[2:0] = repl;
        main_cnt      = 4'd3;
      end
    end else if (is_low) begin
      main_run[2:0] = repl;
      main_cnt      = 4'd3;
    end else if (cu < u16u8je_pkg::CP_ONE_BYTE_END) begin
      main_run[0] = u16u8je_pkg::CH_BSLASH;
      main_cnt    = 4'd2;
      if (cu[7:0] == u16u8je_pkg::CH_QUOTE) begin
        main_run[1] = u16u8je_pkg::CH_QUOTE;
      end else if (cu[7:0] == u16u8je_pkg::CH_BSLASH) begin
        main_run[1] = u16u8je_pkg::CH_BSLASH;
      end else if (cu[7:0] == u16u8je_pkg::CH_LF) begin
        main_run[1] = u16u8je_pkg::CH_N;
      end else if (cu[7:0] == u16u8je_pkg::CH_CR) begin
        main_run[1] = u16u8je_pkg::CH_R;
      end else if (cu[7:0] == u16u8je_pkg::CH_TAB) begin
        main_run[1] = u16u8je_pkg::CH_T;
      end else if (cu < u16u8je_pkg::CP_CTRL_END) begin
        main_run[1] = u16u8je_pkg::CH_U;
        main_run[2] = u16u8je_pkg::CH_ZERO;
        main_run[3] = u16u8je_pkg::CH_ZERO;
        main_run[4] = u16u8je_pkg::hex_digit(cu[7:4]);
        main_run[5] = u16u8je_pkg::hex_digit(cu[3:0]);
        main_cnt    = 4'd6;
      end else begin
        main_run[0] = cu[7:0];
        main_cnt    = 4'd1;
      end
    end else if (cu < u16u8je_pkg::CP_TWO_BYTE_END) begin
      main_run[0] = u16u8je_pkg::LEAD_2 | {3'b0, cu[10:6]};
      main_run[1] = u16u8je_pkg::CONT | {2'b0, cu[5:0]};
      main_cnt    = 4'd2;
    end else begin
      main_run[0] = u16u8je_pkg::LEAD_3 | {4'b0, cu[15:12]};
      main_run[1] = u16u8je_pkg::CONT | {2'b0, cu[11:6]};
      main_run[2] = u16u8je_pkg::CONT | {2'b0, cu[5:0]};
      main_cnt    = 4'd3;
    end
  end

  // Prepend the replacement for an unpaired held high surrogate
  assign new_run = pre ? {main_run[u16u8je_pkg::RUN_MAX-4:0], repl} : main_run;
  assign new_cnt = main_cnt + (pre ? 4'd3 : 4'd0);

  // Handshake: move a byte when the output register is empty or being taken
  assign move     = (cnt_r != '0) && (!ovld_r || !out_stall);
  assign run_free = (cnt_r == '0) || ((cnt_r == 4'd1) && move);
  assign in_stall = !run_free;
  assign in_take  = in_valid && run_free;

  // Next state: load a fresh run on a taken beat, else shift out one byte
  always_comb begin
    pend_nxt = pend_r;
    held_nxt = held_r;
    run_nxt  = run_r;
    cnt_nxt  = cnt_r;
    end_nxt  = end_r;
    if (in_take) begin
      pend_nxt = is_high && !pair && !in_data.last_unit;
      held_nxt = cu[9:0];
      run_nxt  = new_run;
      cnt_nxt  = new_cnt;
      end_nxt  = in_data.last_unit;
    end else if (move) begin
      run_nxt = {8'h00, run_r[u16u8je_pkg::RUN_MAX-1:1]};
      cnt_nxt = cnt_r - 4'd1;
    end
  end

  // Output register: fill from the run head, drop when taken
  always_comb begin
    ovld_nxt  = ovld_r;
    obeat_nxt = obeat_r;
    if (move) begin
      ovld_nxt             = 1'b1;
      obeat_nxt.out_byte   = run_r[0];
      obeat_nxt.run_last   = (cnt_r == 4'd1);
      obeat_nxt.string_end = (cnt_r == 4'd1) && end_r;
    end else if (!out_stall) begin
      ovld_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      cnt_r  <= '0;
      ovld_r <= 1'b0;
    end else begin
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
      ovld_r <= ovld_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    held_r  <= held_nxt;
    run_r   <= run_nxt;
    end_r   <= end_nxt;
    obeat_r <= obeat_nxt;
  end

  assign out_valid = ovld_r;
  assign out_data  = obeat_r;

endmodule

// ===== rtl/u16u8je_check.sv =====
// Port-level checker for the UTF-16 to UTF-8 JSON escape unit, with its bind.
module u16u8je_check (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_stall,
  input u16u8je_pkg::in_beat_t  in_data,
  input logic                   out_valid,
  input logic                   out_stall,
  input u16u8je_pkg::out_beat_t out_data
);

  // Output register is empty straight after reset
  a_reset_empty: assert property (@(posedge clk) $rose(rst_n) |-> !out_valid)
    else $error("out_valid high straight after reset");

  // A stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  // End of string only closes a run
  a_end_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.string_end |-> out_data.run_last)
    else $error("string_end without run_last");

  // Bytes of an unfinished run still wait, so the input must stall
  a_run_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.run_last && out_stall |-> in_stall)
    else $error("input taken while a run is unfinished and the output is stalled");

endmodule

bind utf16_to_utf8_json_escape_unit u16u8je_check u_check (.*);

// ===== tb/sv/tb_top.sv =====
// Testbench for the UTF-16 to UTF-8 JSON escape unit: directed, random and hold-off tests.
module tb_top;

  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          HOLD_OFF_LEN   = 300;
  localparam int          DRAIN_CYCLES   = 20;
  localparam int          EXP_DEPTH      = 4096;
  localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  u16u8je_pkg::in_beat_t  in_data   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  u16u8je_pkg::out_beat_t out_data;

  // Transcoder state as seen from outside
  logic       surr_held = 1'b0;
  logic [9:0] surr_bits = '0;

  // Bytes of the run being worked out for one code unit
  logic [7:0] run_buf [9];
  int         run_len = 0;

  // Expected byte beats, oldest at exp_head
  u16u8je_pkg::out_beat_t expected_beats [EXP_DEPTH];
  int exp_head = 0;
  int exp_tail = 0;

  int in_gap_max   = 0;
  int out_gap_max  = 0;
  int hold_off_len = 0;
  int fail_count   = 0;
  int byte_count   = 0;
  int idle_cycles  = 0;

  utf16_to_utf8_json_escape_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #6 clk = ~clk;

  // Append one byte to the current run
  function automatic void add_run_byte(input logic [7:0] b);
    if (run_len < 9) begin
      run_buf[run_len] = b;
      run_len++;
    end
  endfunction

  // Append the escaped UTF-8 form of one code point to the current run
  function automatic void add_code_point(input logic [20:0] cp);
    logic [3:0] hi_nib;
    logic [3:0] lo_nib;
    hi_nib = cp[7:4];
    lo_nib = cp[3:0];
    if (cp < 21'h80) begin
      case (cp[7:0])
        u16u8je_pkg::CH_QUOTE: begin
          add_run_byte(u16u8je_pkg::CH_BSLASH);
          add_run_byte(u16u8je_pkg::CH_QUOTE);
        end
        u16u8je_pkg::CH_BSLASH: begin
          add_run_byte(u16u8je_pkg::CH_BSLASH);
          add_run_byte(u16u8je_pkg::CH_BSLASH);
        end
        u16u8je_pkg::CH_LF: begin
          add_run_byte(u16u8je_pkg::CH_BSLASH);
          add_run_byte(u16u8je_pkg::CH_N);
        end
        u16u8je_pkg::CH_CR: begin
          add_run_byte(u16u8je_pkg::CH_BSLASH);
          add_run_byte(u16u8je_pkg::CH_R);
        end
        u16u8je_pkg::CH_TAB: begin
          add_run_byte(u16u8je_pkg::CH_BSLASH);
          add_run_byte(u16u8je_pkg::CH_T);
        end
        default: begin
          if (cp < 21'h20) begin
            add_run_byte(u16u8je_pkg::CH_BSLASH);
            add_run_byte(u16u8je_pkg::CH_U);
            add_run_byte(u16u8je_pkg::CH_ZERO);
            add_run_byte(u16u8je_pkg::CH_ZERO);
            add_run_byte((hi_nib < 4'd10) ? 8'h30 + {4'h0, hi_nib}
                                          : 8'h41 + {4'h0, hi_nib} - 8'd10);
            add_run_byte((lo_nib < 4'd10) ? 8'h30 + {4'h0, lo_nib}
                                          : 8'h41 + {4'h0, lo_nib} - 8'd10);
          end else begin
            add_run_byte(cp[7:0]);
          end
        end
      endcase
    end else if (cp < 21'h800) begin
      add_run_byte({3'b110, cp[10:6]});
      add_run_byte({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      add_run_byte({4'b1110, cp[15:12]});
      add_run_byte({2'b10, cp[11:6]});
      add_run_byte({2'b10, cp[5:0]});
    end else begin
      add_run_byte({5'b11110, cp[20:18]});
      add_run_byte({2'b10, cp[17:12]});
      add_run_byte({2'b10, cp[11:6]});
      add_run_byte({2'b10, cp[5:0]});
    end
  endfunction

  // Work out the byte run of one accepted code unit and queue it
  function automatic void transcode_unit(input logic [15:0] cu, input logic lst);
    logic                   paired;
    int                     n;
    u16u8je_pkg::out_beat_t beat;
    paired  = 1'b0;
    run_len = 0;
    if (surr_held) begin
      surr_held = 1'b0;
      if (cu[15:10] == u16u8je_pkg::LOW_SURR_TAG) begin
        add_code_point(u16u8je_pkg::CP_SUPP_BASE + {1'b0, surr_bits, cu[9:0]});
        paired = 1'b1;
      end else begin
        add_code_point(REPLACEMENT_CP);
      end
      surr_bits = '0;
    end
    if (!paired) begin
      if (cu[15:10] == u16u8je_pkg::HIGH_SURR_TAG) begin
        if (lst) begin
          add_code_point(REPLACEMENT_CP);
        end else begin
          surr_held = 1'b1;
          surr_bits = cu[9:0];
        end
      end else if (cu[15:10] == u16u8je_pkg::LOW_SURR_TAG) begin
        add_code_point(REPLACEMENT_CP);
      end else begin
        add_code_point({5'd0, cu});
      end
    end
    n = run_len;
    for (int k = 0; k < n; k++) begin
      beat.out_byte   = run_buf[k];
      beat.run_last   = (k == n - 1);
      beat.string_end = (k == n - 1) && lst;
      expected_beats[exp_tail % EXP_DEPTH] = beat;
      exp_tail++;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at byte %0d: %s", byte_count, msg);
    fail_count++;
  endtask

  // Offer one code unit after a random gap and hold it until taken
  task automatic send_unit(input logic [15:0] cu, input logic lst);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{code_unit: cu, last_unit: lst};
    do @(posedge clk); while (in_stall);
    transcode_unit(cu, lst);
  endtask

  // Draw one code unit of the class that kind selects
  function automatic logic [15:0] random_unit(input int kind);
    logic [7:0] escapes [6];
    escapes = '{u16u8je_pkg::CH_QUOTE, u16u8je_pkg::CH_BSLASH, u16u8je_pkg::CH_LF,
                u16u8je_pkg::CH_CR, u16u8je_pkg::CH_TAB, 8'h7F};
    if (kind < 35) begin
      return 16'($urandom_range(16'h20, 16'h7E));
    end else if (kind < 45) begin
      return {8'h00, escapes[$urandom_range(0, 5)]};
    end else if (kind < 55) begin
      return 16'($urandom_range(16'h00, 16'h1F));
    end else if (kind < 70) begin
      return 16'($urandom_range(16'h80, 16'h7FF));
    end else if (kind < 85) begin
      if ($urandom_range(0, 1) == 0) begin
        return 16'($urandom_range(16'h800, 16'hD7FF));
      end
      return 16'($urandom_range(16'hE000, 16'hFFFF));
    end else if (kind < 90) begin
      return 16'($urandom_range(16'hDC00, 16'hDFFF));
    end else if (kind < 95) begin
      return 16'($urandom_range(16'hD800, 16'hDBFF));
    end
    return 16'($urandom_range(0, 16'hFFFF));
  endfunction

  // Send one string of len units, mostly well formed with surrogate pairs
  task automatic send_random_string(input int len);
    int i;
    int kind;
    i = 0;
    while (i < len) begin
      kind = $urandom_range(0, 99);
      if (kind < 15 && i + 1 < len) begin
        send_unit(16'hD800 | 16'($urandom_range(0, 1023)), 1'b0);
        send_unit(16'hDC00 | 16'($urandom_range(0, 1023)), (i + 2 == len));
        i += 2;
      end else begin
        send_unit(random_unit(kind), (i + 1 == len));
        i++;
      end
    end
  endtask

  task automatic test_direct_characters();
    in_gap_max  = 0;
    out_gap_max = 0;
    send_unit(16'h0000, 1'b0);
    send_unit(16'h001F, 1'b0);
    send_unit(16'h0020, 1'b0);
    send_unit({8'h00, u16u8je_pkg::CH_QUOTE}, 1'b0);
    send_unit({8'h00, u16u8je_pkg::CH_BSLASH}, 1'b0);
    send_unit({8'h00, u16u8je_pkg::CH_LF}, 1'b0);
    send_unit({8'h00, u16u8je_pkg::CH_CR}, 1'b0);
    send_unit({8'h00, u16u8je_pkg::CH_TAB}, 1'b0);
    send_unit(16'h007F, 1'b1);
    send_unit(16'h0080, 1'b0);
    send_unit(16'h07FF, 1'b0);
    send_unit(16'h0800, 1'b0);
    send_unit(16'hFFFD, 1'b0);
    send_unit(16'hFFFF, 1'b1);
  endtask

  task automatic test_surrogate_cases();
    in_gap_max  = 3;
    out_gap_max = 3;
    // lowest and highest pairs
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDBFF, 1'b0);
    send_unit(16'hDFFF, 1'b1);
    // held high followed by a plain character, then by a control
    send_unit(16'hD800, 1'b0);
    send_unit(16'h0041, 1'b0);
    send_unit(16'hD801, 1'b0);
    send_unit(16'h0001, 1'b1);
    // high surrogate on the final unit, alone and after an unpaired one
    send_unit(16'hDA00, 1'b1);
    send_unit(16'hD800, 1'b0);
    send_unit(16'hDBFF, 1'b1);
    // lone low surrogates, then a high replaced by a second high that pairs
    send_unit(16'hDC00, 1'b0);
    send_unit(16'hDFFF, 1'b0);
    send_unit(16'hD800, 1'b0);
    send_unit(16'hD900, 1'b0);
    send_unit(16'hDC05, 1'b1);
  endtask

  task automatic test_random_strings();
    int sent;
    int len;
    // no idling first, then random gaps on both sides
    in_gap_max  = 0;
    out_gap_max = 0;
    sent = 0;
    while (sent < 60) begin
      len = $urandom_range(1, 8);
      send_random_string(len);
      sent += len;
    end
    in_gap_max  = 6;
    out_gap_max = 6;
    while (sent < 192) begin
      len = $urandom_range(1, 8);
      send_random_string(len);
      sent += len;
    end
  endtask

  task automatic test_output_hold_off();
    in_gap_max   = 0;
    out_gap_max  = 2;
    hold_off_len = HOLD_OFF_LEN;
    for (int i = 0; i < 24; i++) begin
      send_unit(random_unit($urandom_range(45, 84)), (i == 23));
    end
  endtask

  // Result side: random stall per beat, plus one long hold-off on request
  initial begin
    int wait_cycles;
    forever begin
      wait_cycles = $urandom_range(0, out_gap_max);
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      if (hold_off_len > 0) begin
        out_stall <= 1'b1;
        repeat (hold_off_len) @(posedge clk);
        hold_off_len = 0;
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Compare each accepted byte beat with the oldest expected one
  always @(posedge clk) begin
    u16u8je_pkg::out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (exp_head == exp_tail) begin
        report_mismatch($sformatf("unexpected beat byte=%02h", out_data.out_byte));
      end else begin
        want = expected_beats[exp_head % EXP_DEPTH];
        exp_head++;
        if (out_data.out_byte !== want.out_byte) begin
          report_mismatch($sformatf("out_byte got %02h want %02h",
                                    out_data.out_byte, want.out_byte));
        end
        if (out_data.run_last !== want.run_last) begin
          report_mismatch($sformatf("run_last got %b want %b",
                                    out_data.run_last, want.run_last));
        end
        if (out_data.string_end !== want.string_end) begin
          report_mismatch($sformatf("string_end got %b want %b",
                                    out_data.string_end, want.string_end));
        end
      end
      byte_count++;
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_direct_characters();
    test_surrogate_cases();
    test_random_strings();
    test_output_hold_off();
    in_valid <= 1'b0;
    // drain, then allow for any stray beats
    while (exp_head != exp_tail) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && exp_head == exp_tail) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
